@@ hw/rtl/gpe_pkg.sv @@
package gpe_pkg;

  localparam int unsigned IdxW     = 12;
  localparam int unsigned DivW     = 13;
  localparam int unsigned ChW      = 8;
  localparam int unsigned NCh      = 3;
  localparam int unsigned RgbW     = NCh * ChW;
  localparam int unsigned ProdW    = ChW + IdxW;
  localparam int unsigned MixSteps = ChW;
  localparam int unsigned ArgbW    = 32;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [DivW-1:0] MaxEntries = 13'd4096;
  localparam logic [RgbW-1:0] WhiteRgb   = 24'hFFFFFF;
  localparam logic [ChW-1:0]  AlphaOpaque = 8'hFF;

  localparam logic [1:0] ModeMono   = 2'd0;
  localparam logic [1:0] ModeMulti  = 2'd1;
  localparam logic [1:0] ModeStripe = 2'd2;
  localparam logic [1:0] ModeUndef  = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode       = 3'd0,
    CfgColorA     = 3'd1,
    CfgColorB     = 3'd2,
    CfgColorC     = 3'd3,
    CfgEntryCount = 3'd4,
    CfgColorCount = 3'd5
  } cfg_idx_e;

  // sideband carried alongside a divider
  typedef struct packed {
    logic            ok;
    logic [DivW-1:0] val;
  } div_tag_t;

  typedef struct packed {
    logic            q;
    logic [DivW-1:0] rem;
  } div_step_t;

  // one restoring division step; rem < den on entry
  function automatic div_step_t div_step(input logic [DivW-1:0] rem,
                                         input logic bit_in,
                                         input logic [DivW-1:0] den);
    logic [DivW:0] t;
    logic [DivW:0] diff;
    div_step_t     r;
    t    = {rem, bit_in};
    diff = t - {1'b0, den};
    r.q  = (t >= {1'b0, den});
    r.rem = r.q ? diff[DivW-1:0] : t[DivW-1:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/gpe_div.sv @@
module gpe_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [gpe_pkg::DivW-1:0] num_i,
  input  logic [gpe_pkg::DivW-1:0] den_i,
  input  gpe_pkg::div_tag_t       tag_i,
  output logic                    valid_o,
  output logic [gpe_pkg::DivW-1:0] quo_o,
  output logic [gpe_pkg::DivW-1:0] rem_o,
  output gpe_pkg::div_tag_t       tag_o
);
  import gpe_pkg::*;

  // one quotient bit per stage
  logic [DivW-1:0] valid_q;
  logic [DivW-1:0] num_q [DivW];
  logic [DivW-1:0] den_q [DivW];
  logic [DivW-1:0] rem_q [DivW];
  logic [DivW-1:0] quo_q [DivW];
  div_tag_t        tag_q [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic            v_in;
    logic [DivW-1:0] num_in;
    logic [DivW-1:0] den_in;
    logic [DivW-1:0] rem_in;
    logic [DivW-1:0] quo_in;
    div_tag_t        tag_in;
    div_step_t       st;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign st = div_step(rem_in, num_in[DivW-1-k], den_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in;
        den_q[k] <= den_in;
        rem_q[k] <= st.rem;
        quo_q[k] <= {quo_in[DivW-2:0], st.q};
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = valid_q[DivW-1];
  assign quo_o   = quo_q[DivW-1];
  assign rem_o   = rem_q[DivW-1];
  assign tag_o   = tag_q[DivW-1];

endmodule

@@ hw/rtl/gpe_mix.sv @@
module gpe_mix (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic                     ok_i,
  input  logic [gpe_pkg::DivW-1:0] seg_i,
  input  logic [gpe_pkg::IdxW-1:0] j_i,
  input  logic [gpe_pkg::DivW-1:0] len_i,
  input  logic [1:0]               mode_i,
  input  logic [gpe_pkg::RgbW-1:0] color_a_i,
  input  logic [gpe_pkg::RgbW-1:0] color_b_i,
  input  logic [gpe_pkg::RgbW-1:0] color_c_i,
  output logic                     valid_o,
  output logic [gpe_pkg::ArgbW-1:0] argb_o,
  output logic                     in_range_o
);
  import gpe_pkg::*;

  // select endpoints
  logic [RgbW-1:0] s_sel, e_sel;

  always_comb begin
    s_sel = color_a_i;
    e_sel = color_b_i;
    case (mode_i)
      ModeMono: begin
        if (seg_i == '0) begin
          s_sel = WhiteRgb;  e_sel = color_a_i;
        end else if (seg_i == 13'd1) begin
          s_sel = color_a_i; e_sel = WhiteRgb;
        end else begin
          s_sel = WhiteRgb;  e_sel = WhiteRgb;
        end
      end
      ModeMulti: begin
        if (seg_i == '0) begin
          s_sel = color_a_i; e_sel = color_b_i;
        end else if (seg_i == 13'd1) begin
          s_sel = color_b_i; e_sel = color_c_i;
        end else begin
          s_sel = color_c_i; e_sel = color_c_i;
        end
      end
      default: begin
        s_sel = color_a_i;
        e_sel = color_b_i;
      end
    endcase
  end

  // stage 1: signed difference as sign and magnitude
  logic                v1_q, ok1_q;
  logic [RgbW-1:0]     s1_q;
  logic [NCh-1:0]      neg1_q;
  logic [ChW-1:0]      mag1_q [NCh];
  logic [IdxW-1:0]     j1_q;
  logic [DivW-1:0]     len1_q;

  logic [NCh-1:0]      neg_d;
  logic [ChW-1:0]      mag_d [NCh];

  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      neg_d[c] = e_sel[c*ChW +: ChW] < s_sel[c*ChW +: ChW];
      mag_d[c] = neg_d[c] ? s_sel[c*ChW +: ChW] - e_sel[c*ChW +: ChW]
                          : e_sel[c*ChW +: ChW] - s_sel[c*ChW +: ChW];
    end
  end

  // stage 2: product magnitude*j
  logic                v2_q, ok2_q;
  logic [RgbW-1:0]     s2_q;
  logic [NCh-1:0]      neg2_q;
  logic [ProdW-1:0]    prod2_q [NCh];
  logic [DivW-1:0]     len2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok1_q  <= ok_i;
      s1_q   <= s_sel;
      neg1_q <= neg_d;
      j1_q   <= j_i;
      len1_q <= len_i;
      for (int c = 0; c < NCh; c++) begin
        mag1_q[c] <= mag_d[c];
      end
      ok2_q  <= ok1_q;
      s2_q   <= s1_q;
      neg2_q <= neg1_q;
      len2_q <= len1_q;
      for (int c = 0; c < NCh; c++) begin
        prod2_q[c] <= mag1_q[c] * j1_q;
      end
    end
  end

  // divide stages: quotient fits 8 bits, so the top product bits seed the remainder
  logic [MixSteps-1:0] vd_q;
  logic                okd_q  [MixSteps];
  logic [RgbW-1:0]     sd_q   [MixSteps];
  logic [NCh-1:0]      negd_q [MixSteps];
  logic [DivW-1:0]     lend_q [MixSteps];
  logic [DivW-1:0]     remd_q [MixSteps][NCh];
  logic [ChW-1:0]      quod_q [MixSteps][NCh];
  logic [ChW-1:0]      lod_q  [MixSteps][NCh];

  for (genvar k = 0; k < MixSteps; k++) begin : g_step
    logic            v_in, ok_in;
    logic [RgbW-1:0] s_in;
    logic [NCh-1:0]  neg_in;
    logic [DivW-1:0] len_in;
    logic [DivW-1:0] rem_in [NCh];
    logic [ChW-1:0]  quo_in [NCh];
    logic [ChW-1:0]  lo_in  [NCh];
    div_step_t       st     [NCh];

    if (k == 0) begin : g_first
      assign v_in   = v2_q;
      assign ok_in  = ok2_q;
      assign s_in   = s2_q;
      assign neg_in = neg2_q;
      assign len_in = len2_q;
      for (genvar c = 0; c < NCh; c++) begin : g_ch
        assign rem_in[c] = {1'b0, prod2_q[c][ProdW-1:ChW]};
        assign quo_in[c] = '0;
        assign lo_in[c]  = prod2_q[c][ChW-1:0];
      end
    end else begin : g_next
      assign v_in   = vd_q[k-1];
      assign ok_in  = okd_q[k-1];
      assign s_in   = sd_q[k-1];
      assign neg_in = negd_q[k-1];
      assign len_in = lend_q[k-1];
      for (genvar c = 0; c < NCh; c++) begin : g_ch
        assign rem_in[c] = remd_q[k-1][c];
        assign quo_in[c] = quod_q[k-1][c];
        assign lo_in[c]  = lod_q[k-1][c];
      end
    end

    for (genvar c = 0; c < NCh; c++) begin : g_ch_step
      assign st[c] = div_step(rem_in[c], lo_in[c][ChW-1-k], len_in);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k] <= 1'b0;
      end else if (en_i) begin
        vd_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        okd_q[k]  <= ok_in;
        sd_q[k]   <= s_in;
        negd_q[k] <= neg_in;
        lend_q[k] <= len_in;
        for (int c = 0; c < NCh; c++) begin
          remd_q[k][c] <= st[c].rem;
          quod_q[k][c] <= {quo_in[c][ChW-2:0], st[c].q};
          lod_q[k][c]  <= lo_in[c];
        end
      end
    end
  end

  // output register: floor for negative slopes rounds away from zero
  logic                valid_q, in_range_q;
  logic [ArgbW-1:0]    argb_q;
  logic [RgbW-1:0]     rgb_d;
  logic [ChW-1:0]      mag_q_v, adj;

  always_comb begin
    rgb_d   = '0;
    mag_q_v = '0;
    adj     = '0;
    for (int c = 0; c < NCh; c++) begin
      mag_q_v = quod_q[MixSteps-1][c] + ChW'(remd_q[MixSteps-1][c] != '0);
      adj     = negd_q[MixSteps-1][c] ? ChW'(8'd0 - mag_q_v) : quod_q[MixSteps-1][c];
      rgb_d[c*ChW +: ChW] = sd_q[MixSteps-1][c*ChW +: ChW] + adj;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vd_q[MixSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_range_q <= okd_q[MixSteps-1];
      argb_q     <= okd_q[MixSteps-1] ? {AlphaOpaque, rgb_d} : '0;
    end
  end

  assign valid_o    = valid_q;
  assign argb_o     = argb_q;
  assign in_range_o = in_range_q;

endmodule

@@ hw/rtl/gradient_palette_entry.sv @@
// Stages from an accepted word to its result word:
// 13-stage length divider, 13-stage index divider, 2 mix stages,
// 8 per-channel divide stages, 1 output register.
// Throughput: one word per cycle unless stalled; all stages advance together.
// Reset: asynchronous active low; clears valid bits and loads register defaults.
module gradient_palette_entry (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config write port
  input  logic                        cfg_we_i,
  input  logic [gpe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gpe_pkg::RgbW-1:0]    cfg_data_i,
  // index channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gpe_pkg::IdxW-1:0]    entry_index_i,
  // color channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gpe_pkg::ArgbW-1:0]   argb_color_o,
  output logic                        in_range_o
);
  import gpe_pkg::*;

  // ---------------------------------------------------------------
  // Config registers. The user must make writes land only while the pipe is
  // empty, as later stages read them directly; the block does not enforce it.
  // ---------------------------------------------------------------
  logic [1:0]      mode_q;
  logic [RgbW-1:0] color_a_q, color_b_q, color_c_q;
  logic [DivW-1:0] entry_count_q, color_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeMono;
      color_a_q     <= '0;
      color_b_q     <= WhiteRgb;
      color_c_q     <= WhiteRgb;
      entry_count_q <= 13'd256;
      color_count_q <= 13'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMode:       mode_q        <= cfg_data_i[1:0];
        CfgColorA:     color_a_q     <= cfg_data_i;
        CfgColorB:     color_b_q     <= cfg_data_i;
        CfgColorC:     color_c_q     <= cfg_data_i;
        CfgEntryCount: entry_count_q <= cfg_data_i[DivW-1:0];
        CfgColorCount: color_count_q <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Flow control: every stage moves when the output slot is free.
  // ---------------------------------------------------------------
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------
  // Entry: clamp count, pick divisor for segment length.
  // Mono splits in two; multi and stripe by color_count-1.
  // ---------------------------------------------------------------
  logic [DivW-1:0] count_clamp, den_len;
  logic            ok_pre;
  div_tag_t        tag_a_in;

  always_comb begin
    count_clamp = (entry_count_q > MaxEntries) ? MaxEntries : entry_count_q;
    if (mode_q == ModeMono) begin
      den_len = 13'd2;
    end else if (color_count_q >= 13'd2) begin
      den_len = color_count_q - 13'd1;
    end else begin
      den_len = '0;
    end
    ok_pre = (mode_q != ModeUndef) && (den_len != '0)
          && ({1'b0, entry_index_i} < count_clamp);
    tag_a_in.ok  = ok_pre;
    tag_a_in.val = {1'b0, entry_index_i};
  end

  // length L = count / divisor
  logic            va;
  logic [DivW-1:0] len_a, rem_a;
  div_tag_t        tag_a;

  gpe_div u_len_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .num_i   (count_clamp),
    .den_i   (den_len),
    .tag_i   (tag_a_in),
    .valid_o (va),
    .quo_o   (len_a),
    .rem_o   (rem_a),
    .tag_o   (tag_a)
  );

  // segment and offset = index / L, index mod L
  div_tag_t tag_b_in;
  always_comb begin
    tag_b_in.ok  = tag_a.ok && (len_a != '0) && (rem_a == rem_a);
    tag_b_in.val = len_a;
  end

  logic            vb;
  logic [DivW-1:0] seg_b, rem_b;
  div_tag_t        tag_b;

  gpe_div u_seg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va),
    .num_i   (tag_a.val),
    .den_i   (len_a),
    .tag_i   (tag_b_in),
    .valid_o (vb),
    .quo_o   (seg_b),
    .rem_o   (rem_b),
    .tag_o   (tag_b)
  );

  // per-channel interpolation and output register
  gpe_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vb),
    .ok_i       (tag_b.ok),
    .seg_i      (seg_b),
    .j_i        (rem_b[IdxW-1:0]),
    .len_i      (tag_b.val),
    .mode_i     (mode_q),
    .color_a_i  (color_a_q),
    .color_b_i  (color_b_q),
    .color_c_i  (color_c_q),
    .valid_o    (out_valid_o),
    .argb_o     (argb_color_o),
    .in_range_o (in_range_o)
  );

endmodule

@@ hw/rtl/gpe_checker.sv @@
module gpe_props (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [gpe_pkg::ArgbW-1:0]   argb_color_o,
  input logic                        in_range_o
);
  import gpe_pkg::*;

  // valid colors are always opaque
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> argb_color_o[ArgbW-1 -: ChW] == AlphaOpaque)
    else $error("alpha not opaque");

  // out-of-range words carry black
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> argb_color_o == '0)
    else $error("out-of-range word not zero");

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(argb_color_o)
                                  && $stable(in_range_o))
    else $error("stalled result changed");

  // input only backs up behind a held result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind gradient_palette_entry gpe_props u_gpe_props (.*);

@@ dv/gpe_checker.sv @@
module gpe_checker
  import gpe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [RgbW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [ArgbW-1:0]    argb_color_i,
  input  logic                in_range_i,
  output int                  fail_cnt_o,
  output int                  pending_cnt_o,
  output int                  checked_cnt_o
);

  typedef struct packed {
    logic [ArgbW-1:0] argb;
    logic             ok;
  } color_word_t;

  // shadow of the register file
  logic [1:0]      mode_q;
  logic [RgbW-1:0] col_a_q, col_b_q, col_c_q;
  logic [DivW-1:0] n_entries_q, n_colors_q;

  color_word_t colors_due_q[$];

  // s + floor((e - s) * j / len)
  function automatic logic [ChW-1:0] blend(input logic [ChW-1:0] s, input logic [ChW-1:0] e,
                                           input int j, input int len);
    int num;
    int q;
    num = (int'(e) - int'(s)) * j;
    if (num >= 0) q = num / len;
    else q = -((-num + len - 1) / len);
    return ChW'(int'(s) + q);
  endfunction

  function automatic color_word_t palette_color(input logic [IdxW-1:0] idx);
    int          cnt;
    int          len;
    int          seg;
    int          j;
    logic [RgbW-1:0] s;
    logic [RgbW-1:0] e;
    color_word_t r;
    cnt = int'(n_entries_q);
    if (cnt > int'(MaxEntries)) cnt = int'(MaxEntries);
    len = 0;
    if (mode_q == ModeMono) len = cnt / 2;
    else if (mode_q <= ModeStripe && n_colors_q >= 2) len = cnt / (int'(n_colors_q) - 1);
    r = '0;
    if (mode_q > ModeStripe || len == 0 || int'(idx) >= cnt) return r;
    seg = int'(idx) / len;
    j   = int'(idx) % len;
    if (mode_q == ModeMono) begin
      if (seg == 0) begin s = WhiteRgb; e = col_a_q; end
      else if (seg == 1) begin s = col_a_q; e = WhiteRgb; end
      else begin s = WhiteRgb; e = WhiteRgb; end
    end else if (mode_q == ModeMulti) begin
      if (seg == 0) begin s = col_a_q; e = col_b_q; end
      else if (seg == 1) begin s = col_b_q; e = col_c_q; end
      else begin s = col_c_q; e = col_c_q; end
    end else begin
      s = col_a_q; e = col_b_q;
    end
    r.argb = {AlphaOpaque, blend(s[23:16], e[23:16], j, len),
              blend(s[15:8], e[15:8], j, len), blend(s[7:0], e[7:0], j, len)};
    r.ok = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    color_word_t want;
    if (!rst_ni) begin
      mode_q        <= ModeMono;
      col_a_q       <= '0;
      col_b_q       <= WhiteRgb;
      col_c_q       <= WhiteRgb;
      n_entries_q   <= 13'd256;
      n_colors_q    <= 13'd3;
      colors_due_q.delete();
      fail_cnt_o    <= 0;
      checked_cnt_o <= 0;
      pending_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMode:       mode_q      <= cfg_data_i[1:0];
          CfgColorA:     col_a_q     <= cfg_data_i;
          CfgColorB:     col_b_q     <= cfg_data_i;
          CfgColorC:     col_c_q     <= cfg_data_i;
          CfgEntryCount: n_entries_q <= cfg_data_i[DivW-1:0];
          CfgColorCount: n_colors_q  <= cfg_data_i[DivW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) colors_due_q.push_back(palette_color(entry_index_i));
      if (out_valid_i && !out_stall_i) begin
        if (colors_due_q.size() == 0) begin
          $display("%0t: unexpected word argb=%h in_range=%b", $time, argb_color_i, in_range_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = colors_due_q.pop_front();
          checked_cnt_o <= checked_cnt_o + 1;
          if (want.argb !== argb_color_i || want.ok !== in_range_i) begin
            $display("%0t: mismatch expected argb=%h in_range=%b, actual argb=%h in_range=%b",
                     $time, want.argb, want.ok, argb_color_i, in_range_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      pending_cnt_o <= colors_due_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import gpe_pkg::*;

  // register indexes outside the map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;
  localparam int Latency   = 37;
  localparam int CycleCap  = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RgbW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [IdxW-1:0]    entry_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [ArgbW-1:0]   argb_color_o;
  logic               in_range_o;

  int  fail_cnt, pending_cnt, checked_cnt;
  int  cycle_cnt = 0;
  int  phase_cnt = 0;
  bit  calm = 1'b0;     // no idling on either side near the end

  // current palette geometry, mirrored here to aim indexes at boundaries
  int  cur_count = 256;
  int  cur_seg   = 128;

  gradient_palette_entry uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .entry_index_i,
    .out_valid_o, .out_stall_i, .argb_color_o, .in_range_o
  );

  gpe_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .entry_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .argb_color_i(argb_color_o),
    .in_range_i(in_range_o), .fail_cnt_o(fail_cnt), .pending_cnt_o(pending_cnt),
    .checked_cnt_o(checked_cnt)
  );

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("gradient_palette_entry verification failed");
      $finish;
    end
  end

  // receiver back-pressure: random bursts of stall
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // one register write, only while the pipe is empty; caller drops the enable
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RgbW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // present one word and hold it until taken; maybe idle afterwards
  task automatic send_index(input logic [IdxW-1:0] idx);
    int n;
    in_valid_i    <= 1'b1;
    entry_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0 || out_valid_o) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // load every register, then note the geometry for index aiming
  task automatic program_palette(input logic [1:0] md, input logic [RgbW-1:0] a,
                                 input logic [RgbW-1:0] b, input logic [RgbW-1:0] c,
                                 input logic [DivW-1:0] n_ent, input logic [DivW-1:0] n_col);
    drain();
    write_reg(CfgMode, RgbW'(md));
    write_reg(CfgColorA, a);
    write_reg(CfgColorB, b);
    write_reg(CfgColorC, c);
    write_reg(CfgEntryCount, RgbW'(n_ent));
    write_reg(CfgColorCount, RgbW'(n_col));
    write_reg(CfgSpare6, RgbW'($urandom));
    write_reg(CfgSpare7, RgbW'($urandom));
    cfg_we_i <= 1'b0;
    cur_count = (n_ent > MaxEntries) ? int'(MaxEntries) : int'(n_ent);
    if (md == ModeMono) cur_seg = cur_count / 2;
    else if (n_col >= 2) cur_seg = cur_count / (int'(n_col) - 1);
    else cur_seg = 0;
    phase_cnt++;
  endtask

  // mostly in-range indexes, some near segment edges, some anywhere
  task automatic random_burst(input int n);
    int k;
    int pick;
    logic [IdxW-1:0] idx;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6 && cur_count > 0)
        idx = IdxW'($urandom_range(0, cur_count - 1));
      else if (pick < 8 && cur_seg > 0)
        idx = IdxW'(cur_seg * int'($urandom_range(0, 3)) + int'($urandom_range(0, 2)) - 1);
      else
        idx = IdxW'($urandom);
      send_index(idx);
    end
  endtask

  initial begin
    int p;
    logic [1:0] md;
    logic [DivW-1:0] n_ent, n_col;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset palette (mono, black middle, 256 entries), edges of each segment
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'd127);
    send_index(12'd128);
    send_index(12'd255);
    send_index(12'd256);
    send_index(12'hFFF);

    // directed: multi with three colors, edges of both segments
    program_palette(ModeMulti, 24'h000000, 24'hFFFFFF, 24'h00FF00, 13'd12, 13'd3);
    send_index(12'd0); send_index(12'd5); send_index(12'd6); send_index(12'd11);
    // multi where count does not split evenly: seg 2 gives color_c
    program_palette(ModeMulti, 24'hFF0000, 24'h0000FF, 24'h00FF00, 13'd7, 13'd3);
    send_index(12'd6);
    // stripe with one-entry segments over the full table
    program_palette(ModeStripe, 24'hFFFFFF, 24'h000000, 24'h000000, 13'd4096, 13'd4096);
    send_index(12'd0); send_index(12'd4095);
    // undefined mode, too few colors, oversized entry count
    program_palette(ModeUndef, 24'h123456, 24'h654321, 24'hABCDEF, 13'd100, 13'd3);
    send_index(12'd5);
    program_palette(ModeMulti, 24'h123456, 24'h654321, 24'hABCDEF, 13'd100, 13'd1);
    send_index(12'd5);
    program_palette(ModeStripe, 24'h123456, 24'h654321, 24'hABCDEF, 13'd8191, 13'd0);
    send_index(12'd5);
    program_palette(ModeMono, 24'hFFFFFF, 24'h0, 24'h0, 13'd8191, 13'd8191);
    send_index(12'd4095);
    send_index(12'd2048);

    // random palettes; extremes of the counts turn up often
    for (p = 0; p < 14; p++) begin
      md = ($urandom_range(0, 9) == 0) ? ModeUndef : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        0: n_ent = 13'd2;
        1: n_ent = 13'd4096;
        2: n_ent = DivW'($urandom);
        default: n_ent = DivW'($urandom_range(2, 4096));
      endcase
      case ($urandom_range(0, 7))
        0: n_col = 13'd2;
        1: n_col = DivW'($urandom_range(0, 1));
        2: n_col = DivW'($urandom);
        default: n_col = DivW'($urandom_range(2, 9));
      endcase
      calm = (p >= 12);
      program_palette(md, RgbW'($urandom), RgbW'($urandom), RgbW'($urandom), n_ent, n_col);
      random_burst(78);
    end

    drain();
    $display("covered %0d palette settings, %0d color words compared", phase_cnt, checked_cnt);
    $display("modes mono/multi/stripe/undefined, boundary and out-of-range indexes");
    if (fail_cnt == 0) begin
      $display("gradient_palette_entry verification clean");
    end else begin
      $display("gradient_palette_entry verification failed");
    end
    $finish;
  end

endmodule
